/* hw/rtl/wpcm_pkg.sv */
// types and constants for the window peak count block
`timescale 1ns / 1ps
`default_nettype none

package wpcm_pkg;

  localparam int PARTS_W    = 11;
  localparam int CFG_LEN_W  = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int LEN_MIN    = 3;

  localparam logic REG_WINDOW_LEN = 1'b0;

  // per-request control carried from the flag stage to the accumulate stage
  typedef struct packed {
    logic valid;
    logic flag;
    logic sub;
    logic upd;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/window_peak_count_max_core.sv */
// window peak counter top level: flag ring memory, running sum and best tracker
//
// Input channel in_valid/in_ready carries one sample per request, in_last_sample
// marks the end of a sequence. One request is accepted per cycle when the
// output side is not stalled. The result channel out_valid/out_ready carries one
// request per sequence, produced from the request with in_last_sample set.
// The flag stage writes the flag ring and reads it into rd_r; the accumulate stage
// then updates the running sum and best and loads the output register with the
// result. Throughput is one sample per cycle while in_ready is high, set by the
// single read and single write port of the flag ring, read on every sample.
// A held result does not block input: samples keep flowing until a second
// last sample reaches the accumulate stage while the output register is still
// full, and only then in_ready drops until out_ready is seen.
// The window length is written through the APB port at byte address 0; a
// write clamps the value to 3..WINDOW_MAX and restarts the current sequence.
// Synchronous reset (rst_n low) sets the window length to 3 and clears all
// sequence state; the ring memory needs no clearing pass because only entries
// written in the current sequence are ever read.
`timescale 1ns / 1ps
`default_nettype none

module window_peak_count_max_core
  import wpcm_pkg::*;
#(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 30,
  parameter int INDEX_BITS  = 20
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [SAMPLE_BITS-1:0] in_sample,
  input  wire                    in_last_sample,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [PARTS_W-1:0]     out_best_parts,
  output logic [INDEX_BITS-1:0]  out_best_start,
  output logic                   out_no_window,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [CFG_ADDR_W-1:0]  paddr,
  input  wire  [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W   = $clog2(WINDOW_MAX);
  localparam int CMP_W    = ((INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS) + 1;
  localparam logic [ADDR_W:0] RING_DEPTH = (ADDR_W + 1)'(WINDOW_MAX);
  localparam logic [ADDR_W-1:0] WPTR_LAST = ADDR_W'(WINDOW_MAX - 1);
  localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

  // configuration
  logic [LEN_BITS-1:0] win_len_r, win_len_nxt;
  logic                cfg_wr;
  logic [CFG_DATA_W-1:0] cfg_val;

  // flag stage state
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [SAMPLE_BITS-1:0] prev2_r, prev2_nxt;
  logic [INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]      wptr_r, wptr_nxt;

  // accumulate stage state
  stage_ctl_t             s1_r, s1_nxt;
  logic [INDEX_BITS-1:0]  s1_start_r, s1_start_nxt;
  logic [LEN_BITS-1:0]    cnt_r, cnt_nxt;
  logic [LEN_BITS-1:0]    best_r, best_nxt;
  logic [INDEX_BITS-1:0]  best_pos_r, best_pos_nxt;
  logic                   have_r, have_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [PARTS_W-1:0]     parts_r, parts_nxt;
  logic [INDEX_BITS-1:0]  start_r, start_nxt;
  logic                   nowin_r, nowin_nxt;

  // flag ring
  logic                   ring_mem [WINDOW_MAX];
  logic                   rd_r;

  logic                   accept;
  logic                   s1_go;
  logic [INDEX_BITS-1:0]  e_idx;
  logic [CMP_W-1:0]       e_ext, k_ext, start_ext;
  logic                   e_ge2, e_ge3, e_gek;
  logic                   peak;
  logic [ADDR_W:0]        newest_ext, back_ext, slot_ext;
  logic [ADDR_W-1:0]      slot;
  logic [LEN_BITS-1:0]    cnt_sum;
  logic                   take_best;
  logic [LEN_BITS-1:0]    best_fin;
  logic [INDEX_BITS-1:0]  best_pos_fin;
  logic                   have_fin;
  logic [LEN_BITS:0]      parts_sum;

  // apb port
  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(win_len_r);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);

  always_comb begin
    cfg_val = {{(CFG_DATA_W - CFG_LEN_W){1'b0}}, pwdata[CFG_LEN_W-1:0]};
    if (cfg_val < CFG_DATA_W'(LEN_MIN)) begin
      cfg_val = CFG_DATA_W'(LEN_MIN);
    end
    if (cfg_val > CFG_DATA_W'(WINDOW_MAX)) begin
      cfg_val = CFG_DATA_W'(WINDOW_MAX);
    end
    win_len_nxt = cfg_wr ? LEN_BITS'(cfg_val) : win_len_r;
  end

  // handshake
  assign s1_go    = s1_r.valid && !(s1_r.last && out_valid_r && !out_ready);
  assign in_ready = !(s1_r.valid && !s1_go);
  assign accept   = in_valid && in_ready;

  // flag stage
  always_comb begin
    e_idx = (idx_r != IDX_MAX) ? idx_r + 1'b1 : idx_r;
    e_ext = CMP_W'(e_idx);
    k_ext = CMP_W'(win_len_r);
    e_ge2 = e_ext >= CMP_W'(2);
    e_ge3 = e_ext >= CMP_W'(3);
    e_gek = e_ext >= k_ext;
    start_ext = e_ext - k_ext + CMP_W'(1);
    peak  = e_ge3 && (prev_r > prev2_r) && (prev_r > in_sample);

    newest_ext = {1'b0, wptr_r};
    back_ext   = (ADDR_W + 1)'(win_len_r - LEN_BITS'(2));
    if (newest_ext >= back_ext) begin
      slot_ext = newest_ext - back_ext;
    end else begin
      slot_ext = newest_ext + RING_DEPTH - back_ext;
    end
    slot = slot_ext[ADDR_W-1:0];

    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    idx_nxt   = idx_r;
    wptr_nxt  = wptr_r;
    s1_start_nxt = s1_start_r;
    if (accept) begin
      s1_start_nxt = start_ext[INDEX_BITS-1:0];
      if (in_last_sample) begin
        prev_nxt  = '0;
        prev2_nxt = '0;
        idx_nxt   = '0;
        wptr_nxt  = '0;
      end else begin
        prev_nxt  = in_sample;
        prev2_nxt = prev_r;
        idx_nxt   = e_idx;
        if (e_ge2) begin
          wptr_nxt = (wptr_r == WPTR_LAST) ? '0 : wptr_r + 1'b1;
        end
      end
    end
    if (cfg_wr) begin
      prev_nxt  = '0;
      prev2_nxt = '0;
      idx_nxt   = '0;
      wptr_nxt  = '0;
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (accept) begin
      s1_nxt.valid = 1'b1;
      s1_nxt.flag  = peak;
      s1_nxt.sub   = e_gek && e_ge2;
      s1_nxt.upd   = e_gek;
      s1_nxt.last  = in_last_sample;
    end else if (s1_go) begin
      s1_nxt.valid = 1'b0;
    end
  end

  // flag ring memory
  always_ff @(posedge clk) begin
    if (accept && e_ge2) begin
      ring_mem[wptr_r] <= peak;
    end
    if (accept) begin
      rd_r <= ring_mem[slot];
    end
  end

  // accumulate stage
  always_comb begin
    cnt_sum = cnt_r + LEN_BITS'(s1_r.flag) - ((s1_r.sub) ? LEN_BITS'(rd_r) : '0);
    take_best = s1_r.upd && (!have_r || (cnt_sum > best_r));
    best_fin     = take_best ? cnt_sum : best_r;
    best_pos_fin = take_best ? s1_start_r : best_pos_r;
    have_fin     = have_r || take_best;
    parts_sum    = {1'b0, best_fin} + 1'b1;

    cnt_nxt      = cnt_r;
    best_nxt     = best_r;
    best_pos_nxt = best_pos_r;
    have_nxt     = have_r;
    parts_nxt    = parts_r;
    start_nxt    = start_r;
    nowin_nxt    = nowin_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (s1_go) begin
      if (s1_r.last) begin
        cnt_nxt      = '0;
        best_nxt     = '0;
        best_pos_nxt = '0;
        have_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        parts_nxt    = have_fin ? PARTS_W'(parts_sum) : '0;
        start_nxt    = have_fin ? best_pos_fin : '0;
        nowin_nxt    = !have_fin;
      end else begin
        cnt_nxt      = cnt_sum;
        best_nxt     = best_fin;
        best_pos_nxt = best_pos_fin;
        have_nxt     = have_fin;
      end
    end
    if (cfg_wr) begin
      cnt_nxt      = '0;
      best_nxt     = '0;
      best_pos_nxt = '0;
      have_nxt     = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= LEN_BITS'(LEN_MIN);
      prev_r      <= '0;
      prev2_r     <= '0;
      idx_r       <= '0;
      wptr_r      <= '0;
      s1_r        <= '0;
      cnt_r       <= '0;
      best_r      <= '0;
      best_pos_r  <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_len_r   <= win_len_nxt;
      prev_r      <= prev_nxt;
      prev2_r     <= prev2_nxt;
      idx_r       <= idx_nxt;
      wptr_r      <= wptr_nxt;
      s1_r        <= s1_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      best_pos_r  <= best_pos_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_start_r <= s1_start_nxt;
    parts_r    <= parts_nxt;
    start_r    <= start_nxt;
    nowin_r    <= nowin_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_parts = parts_r;
  assign out_best_start = start_r;
  assign out_no_window  = nowin_r;

endmodule

`default_nettype wire
